/* rtl/rctr_pkg.sv */
`default_nettype none

package rctr_pkg;

	localparam int TABLE_SLOTS = 16;
	localparam int SLOT_W      = $clog2(TABLE_SLOTS);

	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_BEACON = 2'd1;
	localparam logic [1:0] CMD_REPORT = 2'd2;
	localparam logic [1:0] CMD_SELECT = 2'd3;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;

	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	typedef struct packed {
		logic [31:0]       addr;
		logic [15:0]       count;
		logic signed [7:0] strength;
	} entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic clear;
		logic scan;
		logic sort;
		logic publish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] op;
		logic       addr_zero;
		logic       scan_done;
		logic       sort_last;
	} stat_t;

endpackage

`default_nettype wire

/* rtl/router_candidate_table_ranker.sv */
// Channel  Handshake              Payload
// in       in_valid / in_stall    command, node_address, signal_strength
// out      out_valid / out_stall  status, slot_index, best_router, backup_router
//
// One beat is worked on at a time. A clear, and a beacon or report to a zero
// address, pass from acceptance through the execute and finish states to the
// registered result; beacon and report otherwise scan one slot per cycle.
// Select runs TABLE_SLOTS rounds of the odd-even compare-exchange row.
// Reset empties the table at once. A stalled result holds the input stalled.
`default_nettype none

module router_candidate_table_ranker (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [1:0]        command,
	input  wire logic [31:0]       node_address,
	input  wire logic signed [7:0] signal_strength,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [1:0]             status,
	output logic [3:0]             slot_index,
	output logic [31:0]            best_router,
	output logic [31:0]            backup_router
);
	import rctr_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	rctr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	rctr_table u_table (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.command         (command),
		.node_address    (node_address),
		.signal_strength (signal_strength),
		.stat            (stat),
		.status          (status),
		.slot_index      (slot_index),
		.best_router     (best_router),
		.backup_router   (backup_router)
	);

	a_no_accept_on_blocked_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> in_stall)
		else $error("input accepted while the result beat is blocked");

	a_no_result_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> !out_valid)
		else $error("result beat valid right after an input beat");

	a_failed_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_DONE) |-> (slot_index == 4'd0))
		else $error("dropped or ignored beat reports a nonzero slot");

	a_single_command: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clear, cmd.scan, cmd.sort, cmd.publish}))
		else $error("controller issued more than one table command");

endmodule

`default_nettype wire

/* rtl/rctr_ctrl.sv */
`default_nettype none

module rctr_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  wire logic           out_stall,
	input  wire rctr_pkg::stat_t stat,
	output rctr_pkg::cmd_t      cmd
);
	import rctr_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EXEC   = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_SORT   = 3'd3;
	localparam logic [2:0] S_FINISH = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_next;
	logic       out_valid_q;
	logic       accept;

	// A new beat is taken only when the result register is free or drains now.
	assign in_stall  = !((state_q == S_IDLE) && (!out_valid_q || !out_stall));
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd         = '0;
		cmd.load    = accept;
		state_next  = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_next = S_EXEC;
				end
			end
			S_EXEC: begin
				case (stat.op)
					CMD_CLEAR: begin
						cmd.clear  = 1'b1;
						state_next = S_FINISH;
					end
					CMD_SELECT: begin
						state_next = S_SORT;
					end
					default: begin
						state_next = stat.addr_zero ? S_FINISH : S_SCAN;
					end
				endcase
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_done) begin
					state_next = S_FINISH;
				end
			end
			S_SORT: begin
				cmd.sort = 1'b1;
				if (stat.sort_last) begin
					state_next = S_FINISH;
				end
			end
			S_FINISH: begin
				cmd.publish = 1'b1;
				state_next  = S_IDLE;
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/rctr_table.sv */
`default_nettype none

module rctr_table (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rctr_pkg::cmd_t    cmd,
	input  wire logic [1:0]        command,
	input  wire logic [31:0]       node_address,
	input  wire logic signed [7:0] signal_strength,
	output rctr_pkg::stat_t        stat,
	output logic [1:0]             status,
	output logic [3:0]             slot_index,
	output logic [31:0]            best_router,
	output logic [31:0]            backup_router
);
	import rctr_pkg::*;

	entry_t                entry_q [TABLE_SLOTS];
	entry_t                sorted  [TABLE_SLOTS];
	logic [TABLE_SLOTS-2:0] swap;

	logic [1:0]        op_q;
	logic [31:0]       addr_q;
	logic signed [7:0] strength_q;
	logic [SLOT_W-1:0] idx_q;
	logic [SLOT_W-1:0] round_q;
	logic [1:0]        res_status_q;
	logic [SLOT_W-1:0] res_slot_q;

	entry_t cur;
	entry_t upd;
	logic   hit;
	logic   empty;
	logic   idx_last;

	assign cur      = entry_q[idx_q];
	assign hit      = (cur.addr == addr_q);
	assign empty    = (cur.addr == 32'd0);
	assign idx_last = (idx_q == SLOT_W'(TABLE_SLOTS - 1));

	assign stat.op        = op_q;
	assign stat.addr_zero = (addr_q == 32'd0);
	assign stat.scan_done = hit || empty || idx_last;
	assign stat.sort_last = (round_q == SLOT_W'(TABLE_SLOTS - 1));

	// Entry update for a match or for the first empty slot.
	always_comb begin
		upd = cur;
		if (hit) begin
			if (op_q == CMD_BEACON) begin
				upd.count    = 16'd1;
				upd.strength = strength_q;
			end else if (cur.count != COUNT_MAX) begin
				upd.count = cur.count + 16'd1;
			end
		end else begin
			upd.addr  = addr_q;
			upd.count = 16'd1;
			if (op_q == CMD_BEACON) begin
				upd.strength = strength_q;
			end
		end
	end

	// Odd-even transposition: one rank of disjoint compare-exchange cells per
	// cycle. Cells swap only on a strictly greater key, so ties keep their order.
	for (genvar p = 0; p < TABLE_SLOTS - 1; p++) begin : g_cell
		logic [23:0] key_lo;
		logic [23:0] key_hi;
		assign key_lo  = {entry_q[p].count, ~entry_q[p].strength[7],
			entry_q[p].strength[6:0]};
		assign key_hi  = {entry_q[p+1].count, ~entry_q[p+1].strength[7],
			entry_q[p+1].strength[6:0]};
		assign swap[p] = ((p % 2) == int'(round_q[0])) && (key_hi > key_lo);
	end

	always_comb begin
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			sorted[i] = entry_q[i];
			if (i < TABLE_SLOTS - 1) begin
				if (swap[i]) begin
					sorted[i] = entry_q[i+1];
				end
			end
			if (i > 0) begin
				if (swap[i-1]) begin
					sorted[i] = entry_q[i-1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_SLOTS; i++) begin
				entry_q[i] <= '0;
			end
		end else if (cmd.clear) begin
			for (int i = 0; i < TABLE_SLOTS; i++) begin
				entry_q[i].addr  <= 32'd0;
				entry_q[i].count <= 16'd0;
			end
		end else if (cmd.scan && (hit || empty)) begin
			entry_q[idx_q] <= upd;
		end else if (cmd.sort) begin
			entry_q <= sorted;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q         <= CMD_CLEAR;
			idx_q        <= '0;
			round_q      <= '0;
			res_status_q <= ST_DONE;
			res_slot_q   <= '0;
		end else if (cmd.load) begin
			op_q         <= command;
			idx_q        <= '0;
			round_q      <= '0;
			res_slot_q   <= '0;
			if ((command == CMD_BEACON || command == CMD_REPORT) &&
				node_address == 32'd0) begin
				res_status_q <= ST_ZERO;
			end else begin
				res_status_q <= ST_DONE;
			end
		end else if (cmd.scan) begin
			if (hit || empty) begin
				res_slot_q <= idx_q;
			end else if (idx_last) begin
				res_status_q <= ST_FULL;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end else if (cmd.sort) begin
			round_q <= round_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			addr_q     <= node_address;
			strength_q <= signal_strength;
		end
	end

	// Result register; held while the result beat is stalled.
	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			status        <= res_status_q;
			slot_index    <= 4'(res_slot_q);
			best_router   <= entry_q[0].addr;
			backup_router <= entry_q[1].addr;
		end
	end

endmodule

`default_nettype wire
